// ===== rtl/core/dlpcu_pkg.sv =====
// Package with the types, codes and helper functions of the line printer character unpacker.
`timescale 1ns / 1ps

package dlpcu_pkg;

  localparam logic [7:0] LINE_WIDTH = 8'd132;

  localparam int unsigned WORD_W = 18;
  localparam int unsigned CHAR_W = 7;
  localparam int unsigned IN_DATA_W = 64;
  localparam int unsigned OUT_DATA_W = 48;
  localparam int unsigned NUM_SLOTS = 5;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [CHAR_W-1:0] char_t;
  typedef logic [2:0] slot_idx_t;

  typedef enum logic [1:0] {
    OP_PULSE_A = 2'd0,
    OP_PULSE_B = 2'd1,
    OP_WORDS   = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  localparam logic [5:0] P_SKIP     = 6'o01;
  localparam logic [5:0] P_START    = 6'o21;
  localparam logic [5:0] P_START1   = 6'o41;
  localparam logic [5:0] P_INT_OFF  = 6'o61;
  localparam logic [5:0] P_RD_STAT  = 6'o42;
  localparam logic [5:0] P_INT_ON   = 6'o44;
  localparam logic [5:0] P_CLR_DONE = 6'o21;
  localparam logic [5:0] P_CLR_ALL  = 6'o41;

  localparam word_t S_ERR  = 18'o400000;
  localparam word_t S_ALM  = 18'o200000;
  localparam word_t S_OVF  = 18'o100000;
  localparam word_t S_BUSY = 18'o020000;
  localparam word_t S_DON  = 18'o010000;
  localparam word_t S_CLR  = 18'o003777;

  localparam int unsigned S_ERR_BIT = 17;
  localparam int unsigned S_ALM_BIT = 16;
  localparam int unsigned S_OVF_BIT = 15;
  localparam int unsigned S_DON_BIT = 12;

  localparam logic [31:0] CTRL_SET = 32'h081F_3C00;

  // Output item layout, from the lowest bit up.
  localparam int unsigned O_AC_LO    = 0;
  localparam int unsigned O_SKIP     = 18;
  localparam int unsigned O_CVALID   = 19;
  localparam int unsigned O_CODE_LO  = 20;
  localparam int unsigned O_CTRL     = 27;
  localparam int unsigned O_STAT_LO  = 28;
  localparam int unsigned O_IRQ      = 46;

  function automatic logic is_ctrl(input char_t c);
    return (c[6:5] == 2'b00) && CTRL_SET[c[4:0]];
  endfunction

  // Clears the transient bits, derives error from alarm and overflow, and mirrors busy.
  function automatic word_t refresh(input word_t s_in, input logic bsy);
    word_t s;
    s = s_in & ~(S_CLR | S_ERR | S_BUSY);
    if ((s & (S_ALM | S_OVF)) != '0) s = s | S_ERR;
    if (bsy) s = s | S_BUSY;
    return s;
  endfunction

endpackage

// ===== rtl/core/dma_line_printer_char_unpacker.sv =====
// Top level of the line printer controller with its DMA character unpacker.
`timescale 1ns / 1ps

// Usage:
// The in_ channel carries one command item: in_tuser holds the operation (pulse group one,
// pulse group two, DMA word pair) and in_tdata the pulse code, accumulator and two words.
// Each item updates the controller state in the cycle it is accepted and produces one to
// five result items on the out_ channel; the last of them carries out_tlast.
// The first result of an item is valid in the cycle after its acceptance.
// An item occupies the result buffer until its last result is taken: a pulse has one
// result, a packed word pair up to five. The next item is accepted in the cycle its
// predecessor's last result is taken, so single-result items run one per cycle
// when the receiver does not stall; the result buffer and its slot counter set that rate.
// cfg_wr_en writes the printer online flag; it is sampled by later items only.
// Reset (rst_n low, synchronous) clears status, mode, line count and column, enables
// interrupts, marks the printer online and empties the result buffer.
// When the receiver stalls, the current result holds and in_tready stays low until the
// last result of the buffered item is taken.

module dma_line_printer_char_unpacker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // pulse[5:0], ac[23:6], word_first[41:24], word_second[59:42], zero pad
  input  logic [dlpcu_pkg::IN_DATA_W-1:0] in_tdata,
  // op[1:0]
  input  logic [1:0]                     in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // ac_out[17:0], skip[18], char_valid[19], char_code[26:20], is_control[27],
  // status[45:28], irq[46], zero pad
  output logic [dlpcu_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                           out_tlast,
  input  logic                           cfg_wr_en,
  input  logic                           cfg_wr_data
);
  import dlpcu_pkg::*;

  word_t      status_r, status_nxt;
  logic       int_en_r, int_en_nxt;
  logic       unpacked_r, unpacked_nxt;
  logic [8:0] lines_r, lines_nxt;
  logic [7:0] column_r, column_nxt;
  logic       busy_r, busy_nxt;
  logic       online_r;

  logic       buf_valid_r;
  slot_idx_t  slot_r;
  slot_idx_t  nres_r, nres_nxt;
  logic       any_r, any_nxt;
  word_t      acr_r, acr_nxt;
  logic       skip_r, skip_nxt;
  word_t      stat_out_r;
  logic       irq_r, irq_nxt;
  char_t      codes_r [NUM_SLOTS];
  char_t      codes_nxt [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] ctl_r, ctl_nxt;

  op_t        op;
  logic [5:0] pulse;
  word_t      ac, wf, ws;
  logic       accept, pop, is_last;

  assign op    = op_t'(in_tuser);
  assign pulse = in_tdata[5:0];
  assign ac    = in_tdata[23:6];
  assign wf    = in_tdata[41:24];
  assign ws    = in_tdata[59:42];

  assign is_last   = (slot_r == nres_r - 3'd1);
  assign pop       = buf_valid_r & out_tready;
  assign in_tready = ~buf_valid_r | (is_last & out_tready);
  assign accept    = in_tvalid & in_tready;

  always_comb begin
    char_t      c [NUM_SLOTS];
    slot_idx_t  cnt;
    slot_idx_t  n;
    logic [7:0] col;
    logic       ended;
    word_t      s;
    status_nxt   = status_r;
    int_en_nxt   = int_en_r;
    unpacked_nxt = unpacked_r;
    lines_nxt    = lines_r;
    column_nxt   = column_r;
    busy_nxt     = busy_r;
    acr_nxt      = '0;
    skip_nxt     = 1'b0;
    ctl_nxt      = '0;
    n            = '0;
    ended        = 1'b0;
    col          = column_r;
    s            = status_r;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      codes_nxt[i] = '0;
      c[i]         = '0;
    end
    if (unpacked_r) begin
      c[0] = wf[6:0];
      c[1] = ws[6:0];
      cnt  = 3'd2;
    end else begin
      c[0] = wf[17:11];
      c[1] = wf[10:4];
      c[2] = {wf[3:0], ws[17:15]};
      c[3] = ws[14:8];
      c[4] = ws[7:1];
      cnt  = 3'd5;
    end
    unique case (op)
      OP_PULSE_A: begin
        acr_nxt = ac;
        if (pulse == P_SKIP) begin
          skip_nxt = status_r[S_ERR_BIT] | status_r[S_DON_BIT];
        end else begin
          if (pulse == P_START || pulse == P_START1) begin
            unpacked_nxt = wf[0];
            lines_nxt    = (pulse == P_START1) ? 9'd1 : {1'b0, wf[16:9]};
            if (lines_nxt == '0) lines_nxt = 9'd256;
            column_nxt = '0;
            if (online_r) begin
              busy_nxt = 1'b1;
            end else begin
              busy_nxt = 1'b0;
              s = s | S_DON | S_ALM;
            end
          end
          if (pulse == P_INT_OFF) int_en_nxt = 1'b0;
          if (pulse == P_INT_ON) int_en_nxt = 1'b1;
          status_nxt = refresh(s, busy_nxt);
          if (pulse == P_RD_STAT) acr_nxt = status_nxt;
        end
      end
      OP_PULSE_B: begin
        acr_nxt = ac;
        if (pulse == P_CLR_DONE) s = s & ~S_DON;
        if (pulse == P_CLR_ALL) s = '0;
        status_nxt = refresh(s, busy_r);
      end
      OP_WORDS: begin
        if (busy_r) begin
          if (!online_r) begin
            busy_nxt   = 1'b0;
            status_nxt = refresh(s | S_DON | S_ALM, 1'b0);
          end else begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
              if (slot_idx_t'(i) < cnt) begin
                if (is_ctrl(c[i])) begin
                  codes_nxt[n] = c[i];
                  ctl_nxt[n]   = 1'b1;
                  n            = n + 3'd1;
                  col          = '0;
                  ended        = 1'b1;
                end else if (col < LINE_WIDTH) begin
                  codes_nxt[n] = c[i];
                  n            = n + 3'd1;
                  col          = col + 8'd1;
                end else begin
                  s = s | S_OVF;
                end
              end
            end
            column_nxt = col;
            if (ended) begin
              if (lines_r != '0) lines_nxt = lines_r - 9'd1;
              if (lines_nxt == '0) begin
                busy_nxt = 1'b0;
                s = s | S_DON;
              end
            end
            status_nxt = refresh(s, busy_nxt);
          end
        end
      end
      OP_NONE: begin
        acr_nxt = ac;
      end
      default: begin
        acr_nxt = ac;
      end
    endcase
    any_nxt  = (n != '0);
    nres_nxt = any_nxt ? n : 3'd1;
    irq_nxt  = int_en_nxt & status_nxt[S_DON_BIT];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_r    <= '0;
      int_en_r    <= 1'b1;
      unpacked_r  <= 1'b0;
      lines_r     <= '0;
      column_r    <= '0;
      busy_r      <= 1'b0;
      online_r    <= 1'b1;
      buf_valid_r <= 1'b0;
      slot_r      <= '0;
    end else begin
      if (cfg_wr_en) online_r <= cfg_wr_data;
      if (accept) begin
        status_r    <= status_nxt;
        int_en_r    <= int_en_nxt;
        unpacked_r  <= unpacked_nxt;
        lines_r     <= lines_nxt;
        column_r    <= column_nxt;
        busy_r      <= busy_nxt;
        buf_valid_r <= 1'b1;
        slot_r      <= '0;
      end else if (pop) begin
        if (is_last) begin
          buf_valid_r <= 1'b0;
          slot_r      <= '0;
        end else begin
          slot_r <= slot_r + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      nres_r     <= nres_nxt;
      any_r      <= any_nxt;
      acr_r      <= acr_nxt;
      skip_r     <= skip_nxt;
      stat_out_r <= status_nxt;
      irq_r      <= irq_nxt;
      codes_r    <= codes_nxt;
      ctl_r      <= ctl_nxt;
    end
  end

  assign out_tvalid = buf_valid_r;
  assign out_tlast  = is_last;
  assign out_tdata  = {1'b0, irq_r, stat_out_r, any_r & ctl_r[slot_r],
                       any_r ? codes_r[slot_r] : char_t'(0), any_r, skip_r, acr_r};

endmodule

// ===== rtl/core/dlpcu_checker.sv =====
// Port-level checker for the line printer character unpacker, bound to the top level.
`timescale 1ns / 1ps

module dlpcu_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [dlpcu_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic                            out_tlast
);
  import dlpcu_pkg::*;

  logic [17:0] stat;
  assign stat = out_tdata[O_STAT_LO +: 18];

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result item changed while stalled");

  a_err_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> stat[S_ERR_BIT] == (stat[S_ALM_BIT] | stat[S_OVF_BIT]))
    else $error("error bit does not follow alarm and overflow");

  a_irq_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[O_IRQ] |-> stat[S_DON_BIT])
    else $error("interrupt request without done");

  a_no_char_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[O_CVALID] |->
      out_tdata[O_CODE_LO +: 7] == '0 && !out_tdata[O_CTRL] && out_tlast)
    else $error("empty result item carries character fields or is not last");

endmodule

bind dma_line_printer_char_unpacker dlpcu_checker u_dlpcu_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
